// ===== rtl/core/bleadp_pkg.sv =====
// ----------------------------------------------------------------------------
// bleadp_pkg
// Shared types and codes for the advertising data structure parser.
// ----------------------------------------------------------------------------
package bleadp_pkg;

    localparam logic [7:0] MAX_PAYLOAD = 8'd255;
    localparam logic [7:0] POS_MAX     = 8'd255;
    localparam logic [6:0] COUNT_MAX   = 7'd127;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ROLE_LEN  = 2'd0,
        ROLE_TYPE = 2'd1,
        ROLE_DATA = 2'd2,
        ROLE_SKIP = 2'd3
    } role_t;

    typedef enum logic [1:0] {
        STOP_RUN     = 2'd0,
        STOP_ZERO    = 2'd1,
        STOP_OVERRUN = 2'd2,
        STOP_BEYOND  = 2'd3
    } stop_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] position;
        logic [7:0] remaining;
        logic [7:0] cur_type;
        logic [7:0] cur_dlen;
        logic [6:0] count;
        logic [7:0] declared;
        stop_t      stop;
    } parse_state_t;

    typedef struct packed {
        stop_t      stop_reason;
        logic [6:0] structure_count;
        logic       structure_end;
        logic [7:0] data_index;
        logic [7:0] data_length;
        logic [7:0] data_value;
        logic [7:0] ad_type;
        role_t      byte_role;
    } parse_result_t;

endpackage

// ===== rtl/core/bleadp_step.sv =====
// ----------------------------------------------------------------------------
// bleadp_step
// Per-byte classification and parser state update, purely combinational.
// ----------------------------------------------------------------------------
module bleadp_step (
    input  bleadp_pkg::parse_state_t  state,
    input  logic [7:0]                payload_byte,
    input  logic                      payload_start,
    input  logic [7:0]                payload_length,
    output bleadp_pkg::parse_state_t  state_next,
    output bleadp_pkg::parse_result_t result
);

    bleadp_pkg::parse_state_t st;
    logic [8:0]               struct_end_pos;
    logic [7:0]               rem_dec;

    always_comb begin
        st = state;
        // start flag restarts everything and samples the declared length
        if (payload_start) begin
            st.phase     = bleadp_pkg::PH_LEN;
            st.position  = 8'd0;
            st.remaining = 8'd0;
            st.cur_type  = 8'd0;
            st.cur_dlen  = 8'd0;
            st.count     = 7'd0;
            st.stop      = bleadp_pkg::STOP_RUN;
            st.declared  = (payload_length > bleadp_pkg::MAX_PAYLOAD) ?
                           bleadp_pkg::MAX_PAYLOAD : payload_length;
        end

        if (st.stop == bleadp_pkg::STOP_RUN && st.position >= st.declared) begin
            st.stop = bleadp_pkg::STOP_BEYOND;
        end

        struct_end_pos = {1'b0, st.position} + 9'd1 + {1'b0, payload_byte};
        rem_dec        = st.remaining - 8'd1;

        result                 = '0;
        result.byte_role       = bleadp_pkg::ROLE_SKIP;
        result.data_value      = payload_byte;

        if (st.stop == bleadp_pkg::STOP_RUN) begin
            unique case (st.phase)
                bleadp_pkg::PH_LEN: begin
                    if (payload_byte == 8'd0) begin
                        st.stop = bleadp_pkg::STOP_ZERO;
                    end else if (struct_end_pos > {1'b0, st.declared}) begin
                        st.stop = bleadp_pkg::STOP_OVERRUN;
                    end else begin
                        st.cur_dlen        = payload_byte - 8'd1;
                        st.remaining       = payload_byte;
                        st.phase           = bleadp_pkg::PH_TYPE;
                        result.byte_role   = bleadp_pkg::ROLE_LEN;
                        result.data_length = payload_byte - 8'd1;
                    end
                end
                bleadp_pkg::PH_TYPE: begin
                    st.cur_type        = payload_byte;
                    st.remaining       = rem_dec;
                    result.byte_role   = bleadp_pkg::ROLE_TYPE;
                    result.ad_type     = payload_byte;
                    result.data_length = st.cur_dlen;
                    if (rem_dec == 8'd0) begin
                        result.structure_end = 1'b1;
                        st.phase = bleadp_pkg::PH_LEN;
                        if (st.count < bleadp_pkg::COUNT_MAX) begin
                            st.count = st.count + 7'd1;
                        end
                    end else begin
                        st.phase = bleadp_pkg::PH_DATA;
                    end
                end
                bleadp_pkg::PH_DATA: begin
                    result.byte_role   = bleadp_pkg::ROLE_DATA;
                    result.ad_type     = st.cur_type;
                    result.data_length = st.cur_dlen;
                    result.data_index  = st.cur_dlen - st.remaining;
                    st.remaining       = rem_dec;
                    if (rem_dec == 8'd0) begin
                        result.structure_end = 1'b1;
                        st.phase = bleadp_pkg::PH_LEN;
                        if (st.count < bleadp_pkg::COUNT_MAX) begin
                            st.count = st.count + 7'd1;
                        end
                    end
                end
                default: begin
                    st.phase = bleadp_pkg::PH_LEN;
                end
            endcase
        end

        if (st.position < bleadp_pkg::POS_MAX) begin
            st.position = st.position + 8'd1;
        end

        result.structure_count = st.count;
        result.stop_reason     = st.stop;
        state_next             = st;
    end

endmodule

// ===== rtl/core/ble_ad_structure_parser_unit.sv =====
// ----------------------------------------------------------------------------
// ble_ad_structure_parser_unit
// Splits an advertising payload stream into length/type/data structures.
// ----------------------------------------------------------------------------
// channel | dir | tdata                                   | tuser         | tlast
// s_axis  | in  | payload_byte, payload_length            | payload_start | -
// m_axis  | out | ad_type, data_value, data_length,       | byte_role     | structure_end
//         |     | data_index, structure_count, stop_reason|               |
//
// one word in, one word out; each result is held in the result register
// a new word is taken every cycle while the result register is empty or drained
// parser state updates in the same edge that accepts the word
// aresetn clears parser state and the result valid flag
// a stalled m_axis holds its word and backpressures s_axis
// ----------------------------------------------------------------------------
module ble_ad_structure_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // payload_byte[7:0], payload_length[15:8]
    input  logic        s_axis_tuser,  // payload_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // ad_type[7:0], data_value[15:8],
                                       // data_length[23:16], data_index[31:24],
                                       // structure_count[38:32], stop_reason[40:39]
    output logic [1:0]  m_axis_tuser,  // byte_role
    output logic        m_axis_tlast   // structure_end
);

    bleadp_pkg::parse_state_t  state_reg;
    bleadp_pkg::parse_state_t  state_next;
    bleadp_pkg::parse_result_t res_reg;
    bleadp_pkg::parse_result_t res_next;
    logic                      m_valid_reg;
    logic                      s_fire;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    bleadp_step u_step (
        .state          (state_reg),
        .payload_byte   (s_axis_tdata[7:0]),
        .payload_start  (s_axis_tuser),
        .payload_length (s_axis_tdata[15:8]),
        .state_next     (state_next),
        .result         (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = res_reg.byte_role;
    assign m_axis_tlast  = res_reg.structure_end;
    assign m_axis_tdata  = {7'd0, res_reg.stop_reason, res_reg.structure_count,
                            res_reg.data_index, res_reg.data_length,
                            res_reg.data_value, res_reg.ad_type};

    // a completed structure is only ever marked on a type or data word
    a_end_role: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.structure_end |->
            res_reg.byte_role == bleadp_pkg::ROLE_TYPE ||
            res_reg.byte_role == bleadp_pkg::ROLE_DATA)
        else $error("structure end on a word that is not type or data");

    // skipped words always carry a stop reason, parsed words never do
    a_skip_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |->
            ((res_reg.byte_role == bleadp_pkg::ROLE_SKIP) ==
             (res_reg.stop_reason != bleadp_pkg::STOP_RUN)))
        else $error("byte role and stop reason disagree");

    // a completed structure leaves a nonzero count
    a_end_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.structure_end |-> res_reg.structure_count != 7'd0)
        else $error("structure end with zero structure count");

    // parser state only moves when a word is taken
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> $stable(state_reg))
        else $error("parser state changed without an accepted word");

endmodule
